// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the bit reader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define BFVR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BFVR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/bfvr_pkg.sv -----
// Types, codes and constants shared by the bit reader modules.
`default_nettype none

package bfvr_pkg;

  // Default sizes, handed down as top level parameter defaults.
  localparam int DEF_BUF_BYTES  = 4096;
  localparam int DEF_MAX_CHUNKS = 8;

  // Fixed widths of the interface and internal counters.
  localparam int CFG_W      = 13;
  localparam int PTR_W      = 16;
  localparam int NEED_W     = 18;
  localparam int CHUNK_BITS = 4;
  localparam int MAX_FIXED  = 32;

  // Item modes.
  typedef enum logic [2:0] {
    MODE_LOAD   = 3'd0,
    MODE_REWIND = 3'd1,
    MODE_FIXED  = 3'd2,
    MODE_VLI5   = 3'd3,
    MODE_SVLI5  = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_END = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_FETCH,
    S_TAKE,
    S_FINISH
  } state_t;

  // Parsing phase of a read.
  typedef enum logic [1:0] {
    PH_SIGN,
    PH_PREFIX,
    PH_DATA
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   capture;
    logic   start;
    logic   fetch;
    logic   take;
    logic   out_load;
    phase_t phase;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       fix_fail;
    logic       cnt_zero;
    logic       at_end;
    logic       zero_found;
    logic       data_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/bit_field_and_vli5_reader_unit.sv -----
// Top level of the MSB-first bit field reader with VLI5 decode.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+--------------------------------------------
//   input   | in_valid, in_stall  | mode, byte_index, load_byte, bit_count
//   output  | out_valid,out_stall | value, status, bit_position
//   config  | cfg_valid,cfg_ready | buffer_bytes
//
// An item is captured in idle, then passes start, a fetch and a take state for each step, and finish.
// Loads, rewinds, unused modes and fixed reads that fail or are zero wide take no step;
// a read takes one step per buffer byte touched in each sign, prefix and data phase,
// and a fetch that meets the buffer end ends the read.
// Reset is synchronous; buffer contents are not cleared and no clearing pass runs.
// A finished item waits while the output register is held; input stalls until then.
`default_nettype none

module bit_field_and_vli5_reader_unit import bfvr_pkg::*; #(
  parameter int BUF_BYTES  = DEF_BUF_BYTES,
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [2:0]       mode,
  input  wire logic [11:0]      byte_index,
  input  wire logic [7:0]       load_byte,
  input  wire logic [5:0]       bit_count,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [31:0]      value,
  output logic      [1:0]       status,
  output logic      [PTR_W-1:0] bit_position,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] buffer_bytes
);

  dp_cmd_t cmd;
  dp_sts_t st;

  // The length register can be written at any time it is offered.
  assign cfg_ready = 1'b1;

  bfvr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  bfvr_dpath #(
    .BUF_BYTES  (BUF_BYTES),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .buffer_bytes (buffer_bytes),
    .mode         (mode),
    .byte_index   (byte_index),
    .load_byte    (load_byte),
    .bit_count    (bit_count),
    .cmd          (cmd),
    .st           (st),
    .value        (value),
    .status       (status),
    .bit_position (bit_position)
  );

endmodule

`default_nettype wire

// ----- design/bfvr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/bfvr_ctrl.sv -----
// Controller state machine of the bit reader: sequences fetch and take steps.
`default_nettype none

module bfvr_ctrl import bfvr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire dp_sts_t st,
  output dp_cmd_t      cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   out_free;

  // State, phase and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_DATA;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.phase  = phase;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        case (st.mode)
          MODE_FIXED: begin
            if (st.fix_fail || st.cnt_zero) begin
              state_next = S_FINISH;
            end else begin
              phase_next = PH_DATA;
              state_next = S_FETCH;
            end
          end
          MODE_VLI5: begin
            phase_next = PH_PREFIX;
            state_next = S_FETCH;
          end
          MODE_SVLI5: begin
            phase_next = PH_SIGN;
            state_next = S_FETCH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        // Running out of buffer ends the read here.
        state_next = st.at_end ? S_FINISH : S_TAKE;
      end
      S_TAKE: begin
        cmd.take = 1'b1;
        case (phase)
          PH_SIGN: begin
            phase_next = PH_PREFIX;
            state_next = S_FETCH;
          end
          PH_PREFIX: begin
            if (st.zero_found) begin
              phase_next = PH_DATA;
            end
            state_next = S_FETCH;
          end
          PH_DATA: begin
            state_next = st.data_last ? S_FINISH : S_FETCH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/bfvr_dpath.sv -----
// Datapath of the bit reader: buffer, bit pointer, field assembly and result.
`default_nettype none

module bfvr_dpath import bfvr_pkg::*; #(
  parameter int BUF_BYTES  = DEF_BUF_BYTES,
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [CFG_W-1:0] buffer_bytes,
  input  wire logic [2:0]       mode,
  input  wire logic [11:0]      byte_index,
  input  wire logic [7:0]       load_byte,
  input  wire logic [5:0]       bit_count,
  input  wire dp_cmd_t          cmd,
  output dp_sts_t               st,
  output logic      [31:0]      value,
  output logic      [1:0]       status,
  output logic      [PTR_W-1:0] bit_position
);

  localparam int AW    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int CMP_W = 17;

  // Registers.
  logic [CFG_W-1:0]  buf_len;
  logic [PTR_W-1:0]  ptr;
  logic [2:0]        mode_r;
  logic [5:0]        cnt_r;
  logic [NEED_W-1:0] need;
  logic [31:0]       acc;
  logic              sign;
  logic              ovf;
  logic              end_flag;

  // Buffer memory signals.
  logic              mem_we;
  logic [AW+11:0]    idx_ext;
  logic [AW+15:0]    ptr_ext;
  logic [7:0]        rd_data;

  // Combinational datapath.
  logic [CFG_W-1:0]  len_clamped;
  logic [PTR_W-1:0]  vbits;
  logic [PTR_W-1:0]  avail;
  logic [5:0]        cnt_clamped;
  logic [3:0]        left;
  logic [3:0]        avail_s;
  logic [3:0]        need_s;
  logic [3:0]        m;
  logic [3:0]        k;
  logic [3:0]        z;
  logic [3:0]        lead;
  logic [3:0]        pre_step;
  logic [7:0]        cur;
  logic [7:0]        data_bits;
  logic [39:0]       acc_wide;
  logic [NEED_W-1:0] need_pre;
  logic              idx_ok;
  logic              zero_found;

  // Buffer length clamped to the memory size, in bits.
  always_comb begin
    if (CMP_W'(buf_len) > CMP_W'(BUF_BYTES)) begin
      len_clamped = CFG_W'(BUF_BYTES);
    end else begin
      len_clamped = buf_len;
    end
    vbits = {len_clamped, 3'b000};
    avail = vbits - ptr;
  end

  // Fixed read width, clamped to the largest fixed width.
  assign cnt_clamped = (cnt_r > 6'(MAX_FIXED)) ? 6'(MAX_FIXED) : cnt_r;

  // Bits usable from the fetched byte in this step.
  always_comb begin
    left      = 4'd8 - {1'b0, ptr[2:0]};
    avail_s   = (avail >= PTR_W'(8)) ? 4'd8 : avail[3:0];
    need_s    = (need >= NEED_W'(8)) ? 4'd8 : need[3:0];
    m         = (left < avail_s) ? left : avail_s;
    k         = (m < need_s) ? m : need_s;
    cur       = rd_data << ptr[2:0];
    data_bits = cur >> (4'd8 - k);
    acc_wide  = ({8'b0, acc} << k) | {32'b0, data_bits};
  end

  // Leading ones of the fetched bits for the chunk prefix.
  always_comb begin
    z = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (!cur[i]) begin
        z = 4'(7 - i);
      end
    end
    zero_found = (z < m);
    lead       = zero_found ? z : m;
    pre_step   = zero_found ? lead + 4'd1 : lead;
    need_pre   = need + NEED_W'({lead, 2'b00});
  end

  // Status to the controller.
  always_comb begin
    st.mode       = mode_r;
    st.fix_fail   = (ptr > vbits) || (avail < PTR_W'(cnt_clamped));
    st.cnt_zero   = (cnt_clamped == 6'd0);
    st.at_end     = (ptr >= vbits);
    st.zero_found = zero_found;
    st.data_last  = (need == NEED_W'(k));
  end

  // Buffer memory.
  assign idx_ok  = (CMP_W'(byte_index) < CMP_W'(BUF_BYTES));
  assign mem_we  = cmd.capture && (mode == MODE_LOAD) && idx_ok;
  assign idx_ext = {AW'(0), byte_index};
  assign ptr_ext = {AW'(0), ptr};

  bfvr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (load_byte),
    .re    (cmd.fetch),
    .raddr (ptr_ext[AW+2:3]),
    .rdata (rd_data)
  );

  // Configuration register and bit pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len <= '0;
      ptr     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        buf_len <= buffer_bytes;
      end
      if (cmd.capture && (mode == MODE_REWIND)) begin
        ptr <= '0;
      end else if (cmd.take) begin
        case (cmd.phase)
          PH_SIGN:   ptr <= ptr + PTR_W'(1);
          PH_PREFIX: ptr <= ptr + PTR_W'(pre_step);
          PH_DATA:   ptr <= ptr + PTR_W'(k);
          default:   ptr <= ptr;
        endcase
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= mode;
      cnt_r    <= bit_count;
      acc      <= '0;
      sign     <= 1'b0;
      ovf      <= 1'b0;
      end_flag <= 1'b0;
    end else if (cmd.start) begin
      if (mode_r == MODE_FIXED) begin
        need     <= NEED_W'(cnt_clamped);
        end_flag <= st.fix_fail;
      end else begin
        need <= NEED_W'(CHUNK_BITS);
      end
    end else if (cmd.fetch) begin
      if (st.at_end) begin
        end_flag <= 1'b1;
      end
    end else if (cmd.take) begin
      case (cmd.phase)
        PH_SIGN: begin
          sign <= cur[7];
        end
        PH_PREFIX: begin
          need <= need_pre;
          if (zero_found) begin
            ovf <= (need_pre > NEED_W'(MAX_CHUNKS * CHUNK_BITS));
          end
        end
        PH_DATA: begin
          need <= need - NEED_W'(k);
          acc  <= acc_wide[31:0];
        end
        default: begin
          need <= need;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (end_flag) begin
        value  <= '0;
        status <= ST_END;
      end else begin
        value  <= sign ? (32'd0 - acc) : acc;
        status <= ovf ? ST_OVF : ST_OK;
      end
      bit_position <= ptr;
    end
  end

endmodule

`default_nettype wire

// ----- design/bfvr_checker.sv -----
// Port level checks of the bit reader, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module bfvr_checker import bfvr_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [31:0]      value,
  input wire logic [1:0]       status,
  input wire logic [PTR_W-1:0] bit_position
);

  // A stalled result holds its payload.
  `BFVR_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(value) && $stable(status) && $stable(bit_position), "stalled result changed")

  // A read that ran past the buffer end returns a zero value.
  `BFVR_ASSERT(a_end_zero, clk, rst, out_valid && (status == ST_END) |-> (value == 32'd0), "end status with nonzero value")

  // Each item is worked on alone, so the input stalls after a transfer.
  `BFVR_ASSERT(a_busy, clk, rst, in_valid && !in_stall |=> in_stall, "input taken while busy")

  // Reset leaves the unit empty and ready for input.
  `BFVR_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid && !in_stall, "unit not empty after reset")

endmodule

bind bit_field_and_vli5_reader_unit bfvr_checker u_bfvr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .value        (value),
  .status       (status),
  .bit_position (bit_position)
);

`default_nettype wire
